/* rtl/mme_pkg.sv */
// Shared constants for the modular exponentiation block.
package mme_pkg;

	localparam int unsigned EXP_BITS = 32;

	localparam int unsigned MOD_W = 30;

	localparam logic [MOD_W-1:0] MODULUS = 30'd998244353;

	// Twice the modulus, for the final correction of a Barrett remainder
	localparam logic [31:0] MODULUS_X2 = 32'd1996488706;

	// Barrett factor floor(2^60 / modulus), fits in 31 bits
	localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'd998244353);

endpackage

/* rtl/mme_mulmod.sv */
// Modular multiplier: one shared 32x32 multiplier with Barrett reduction over the phases BARRETT, REDUCE, SUB and FIX.
module mme_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mme_pkg::MOD_W-1:0] a,
	input  logic [mme_pkg::MOD_W-1:0] b,
	output logic                      done,
	output logic [mme_pkg::MOD_W-1:0] result
);
	import mme_pkg::*;

	typedef enum logic [2:0] {
		MM_IDLE,
		MM_BARRETT,
		MM_REDUCE,
		MM_SUB,
		MM_FIX
	} mm_state_t;

	mm_state_t         state_q;
	logic [63:0]       mul_q;
	logic [31:0]       p_lo_q;
	logic [31:0]       rem_q;
	logic              done_q;
	logic [MOD_W-1:0]  result_q;

	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [63:0]       product;
	logic [31:0]       rem_fixed;

	// Select operands of the shared multiplier by phase
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			MM_IDLE: begin
				op_a = {2'b00, a};
				op_b = {2'b00, b};
			end
			MM_BARRETT: begin
				op_a = {1'b0, mul_q[59:29]};
				op_b = {1'b0, BARRETT_MU};
			end
			MM_REDUCE: begin
				op_a = {1'b0, mul_q[61:31]};
				op_b = {2'b00, MODULUS};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign product = op_a * op_b;

	// Barrett quotient is short by at most two
	always_comb begin
		if (rem_q >= MODULUS_X2) begin
			rem_fixed = rem_q - MODULUS_X2;
		end else if (rem_q >= {2'b00, MODULUS}) begin
			rem_fixed = rem_q - {2'b00, MODULUS};
		end else begin
			rem_fixed = rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MM_IDLE;
			mul_q    <= '0;
			p_lo_q   <= '0;
			rem_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MM_IDLE: begin
					if (start) begin
						mul_q   <= product;
						state_q <= MM_BARRETT;
					end
				end
				MM_BARRETT: begin
					p_lo_q  <= mul_q[31:0];
					mul_q   <= product;
					state_q <= MM_REDUCE;
				end
				MM_REDUCE: begin
					mul_q   <= product;
					state_q <= MM_SUB;
				end
				MM_SUB: begin
					// true remainder stays below 2^32, so low words suffice
					rem_q   <= p_lo_q - mul_q[31:0];
					state_q <= MM_FIX;
				end
				MM_FIX: begin
					result_q <= rem_fixed[MOD_W-1:0];
					done_q   <= 1'b1;
					state_q  <= MM_IDLE;
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/modular_exponentiation_top.sv */
// Top level: base^exponent mod 998244353 by right-to-left square-and-multiply.
//
//   channel | dir | handshake           | payload
//   s       | in  | s_tvalid/s_tready   | s_tdata: base[29:0], exponent[61:30]
//   m       | out | m_tvalid/m_tready   | m_tdata: power[29:0]
//
// Every modular product runs on the single shared multiplier in mme_mulmod, one at a
// time, and the square after the top set bit is skipped.
// s_tready is high only while the sequencer is idle; a result waiting on m does not
// block the next transaction unless it is still held when the next result is ready.
// Reset is asynchronous, active low, and leaves the block idle with no result pending.
module modular_exponentiation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // base[29:0], exponent[61:30], zero[63:62]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // power[29:0], zero[31:30]
);
	import mme_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_WACC,
		ST_WSQ,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [MOD_W-1:0]    acc_q;
	logic [MOD_W-1:0]    sq_q;
	logic [EXP_BITS-1:0] exp_q;
	logic                start_q;
	logic [MOD_W-1:0]    op_a_q;
	logic [MOD_W-1:0]    op_b_q;
	logic                m_tvalid_q;
	logic [MOD_W-1:0]    power_q;

	logic [MOD_W-1:0]    base_in;
	logic [31:0]         exponent_in;
	logic [MOD_W-1:0]    base_red;
	logic                mm_done;
	logic [MOD_W-1:0]    mm_result;
	logic                out_free;

	assign base_in     = s_tdata[29:0];
	assign exponent_in = s_tdata[61:30];
	// base is below twice the modulus, one subtract reduces it
	assign base_red    = (base_in >= MODULUS) ? (base_in - MODULUS) : base_in;
	assign out_free    = !m_tvalid_q || m_tready;

	mme_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.done   (mm_done),
		.result (mm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			sq_q       <= '0;
			exp_q      <= '0;
			start_q    <= 1'b0;
			op_a_q     <= '0;
			op_b_q     <= '0;
			m_tvalid_q <= 1'b0;
			power_q    <= '0;
		end else begin
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sq_q    <= base_red;
						acc_q   <= MOD_W'(1);
						exp_q   <= EXP_BITS'(exponent_in);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_q == '0) begin
						state_q <= ST_FINISH;
					end else if (exp_q[0]) begin
						start_q <= 1'b1;
						op_a_q  <= acc_q;
						op_b_q  <= sq_q;
						state_q <= ST_WACC;
					end else begin
						start_q <= 1'b1;
						op_a_q  <= sq_q;
						op_b_q  <= sq_q;
						state_q <= ST_WSQ;
					end
				end
				ST_WACC: begin
					if (mm_done) begin
						acc_q <= mm_result;
						// skip the square after the top set bit
						if ((exp_q >> 1) == '0) begin
							state_q <= ST_FINISH;
						end else begin
							start_q <= 1'b1;
							op_a_q  <= sq_q;
							op_b_q  <= sq_q;
							state_q <= ST_WSQ;
						end
					end
				end
				ST_WSQ: begin
					if (mm_done) begin
						sq_q    <= mm_result;
						exp_q   <= exp_q >> 1;
						state_q <= ST_STEP;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						power_q    <= acc_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, power_q};

`ifndef SYNTHESIS
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_WACC || state_q == ST_WSQ))
		else $error("multiplier finished with no product outstanding");

	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (acc_q < MODULUS && sq_q < MODULUS))
		else $error("running values not reduced below the modulus");

	a_no_start_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q ##1 !start_q ##1 !start_q ##1 !start_q)
		else $error("product started while multiplier busy");

	a_output_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata < {2'b00, MODULUS}))
		else $error("result not below the modulus");
`endif

endmodule

/* bench/tb_modular_exponentiation_top.sv */
// Self-checking bench for the modular exponentiation block: directed and random traffic.
module tb_modular_exponentiation_top;
	import mme_pkg::*;

	localparam int N_RANDOM    = 1780;
	localparam int HOLD_AT     = 320;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_WAIT  = 500;
	localparam int STALL_LIMIT = 12000;

	typedef struct packed {
		logic [31:0] exponent;
		logic [29:0] base;
	} pow_job_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	pow_job_t    pending_jobs[$];
	logic [29:0] expected_powers[$];
	pow_job_t    cur_job;
	logic [29:0] want_power;
	int          jobs_taken = 0;
	int          quiet_after = 0;
	int          mismatches = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          sink_hold = 0;
	bit          hold_done = 1'b0;
	int          idle_cycles = 0;

	modular_exponentiation_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Square-and-multiply over the low EXP_BITS bits, base reduced first
	function automatic logic [29:0] expected_power(logic [29:0] b, logic [31:0] e);
		longint unsigned sq;
		longint unsigned acc;
		longint unsigned m;
		m = 64'(MODULUS);
		sq = 64'(b) % m;
		acc = 1;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[29:0];
	endfunction

	task automatic add_job(logic [29:0] b, logic [31:0] e);
		pow_job_t j;
		j.base = b;
		j.exponent = e;
		pending_jobs.insert(pending_jobs.size(), j);
	endtask

	function automatic logic [29:0] random_base();
		case ($urandom_range(0, 7))
			0: return 30'($urandom);
			1: return MODULUS - 30'(1) + 30'($urandom_range(0, 3));
			2: return 30'($urandom_range(0, 3));
			3: return 30'h3FFFFFFF - 30'($urandom_range(0, 7));
			default: return 30'($urandom_range(0, int'(MODULUS) - 1));
		endcase
	endfunction

	function automatic logic [31:0] random_exponent();
		logic [31:0] e;
		int w;
		e = $urandom;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 32'(MODULUS) - 32'($urandom_range(1, 2));
			2, 3, 4: return e;
			default: begin
				// keep most exponents short to bound the run time
				w = $urandom_range(1, 16);
				return e & ((32'd1 << w) - 32'd1);
			end
		endcase
	endfunction

	// Source side: present pending transactions, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_powers.insert(expected_powers.size(),
					expected_power(cur_job.base, cur_job.exponent));
				jobs_taken <= jobs_taken + 1;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered transaction
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (jobs_taken < quiet_after && $urandom_range(0, 7) == 0) begin
				src_gap <= $urandom_range(0, 8);
				s_tvalid <= 1'b0;
			end else if (pending_jobs.size() != 0) begin
				cur_job = pending_jobs.pop_front();
				s_tdata <= {2'b00, cur_job.exponent, cur_job.base};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long sink hold-off while the source keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_hold <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && jobs_taken == HOLD_AT) begin
			sink_hold <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end
	end

	// Sink side: check results against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_powers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected power %0d with nothing pending", m_tdata[29:0]);
				end else begin
					want_power = expected_powers.pop_front();
					if (m_tdata[29:0] !== want_power) begin
						mismatches++;
						if (mismatches <= 10)
							$display("power mismatch: expected %0d, got %0d",
								want_power, m_tdata[29:0]);
					end
				end
			end
			if (sink_hold != 0) begin
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (jobs_taken < quiet_after && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero exponent, zero base, unreduced bases, all-ones patterns
		add_job(30'd0, 32'd0);
		add_job(30'd12345, 32'd0);
		add_job(30'h3FFFFFFF, 32'd0);
		add_job(30'd0, 32'd1);
		add_job(30'd0, 32'hFFFFFFFF);
		add_job(30'd1, 32'hFFFFFFFF);
		add_job(30'd2, 32'd1);
		add_job(30'd2, 32'd29);
		add_job(30'd2, 32'h80000000);
		add_job(MODULUS - 30'd1, 32'd2);
		add_job(MODULUS - 30'd1, 32'd3);
		add_job(MODULUS - 30'd1, 32'hFFFFFFFF);
		add_job(30'd3, 32'(MODULUS) - 32'd1);
		add_job(30'd3, 32'(MODULUS) - 32'd2);
		add_job(MODULUS, 32'd7);
		add_job(MODULUS + 30'd1, 32'hFFFFFFFF);
		add_job(30'h3FFFFFFF, 32'd1);
		add_job(30'h3FFFFFFF, 32'hFFFFFFFF);
		add_job(30'h2AAAAAAA, 32'h55555555);
		add_job(30'h15555555, 32'hAAAAAAAA);
		quiet_after = pending_jobs.size() + N_RANDOM - 150;

		// pause the source until the block has returned everything
		while (pending_jobs.size() != 0 || s_tvalid || expected_powers.size() != 0)
			@(negedge clk);

		for (int n = 0; n < N_RANDOM; n++)
			add_job(random_base(), random_exponent());

		while (pending_jobs.size() != 0 || s_tvalid || expected_powers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatches == 0 && expected_powers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/mme_pkg.sv
rtl/mme_mulmod.sv
rtl/modular_exponentiation_top.sv
bench/tb_modular_exponentiation_top.sv
